// File: rtl/core/cdsf_pkg.sv
// cdsf_pkg: shared types, constants and the BCD helper for the CD status frame builder.
// Used by every module under rtl/core; depends on nothing.
package cdsf_pkg;

   typedef logic [18:0] addr_type;
   typedef logic [7:0]  byte_type;

   // frame bytes 0..11, index = byte position; byte 12 (zero) is added at the output
   typedef logic [11:0][7:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_msg_type;

   localparam int       FramesPerSecond = 75;
   localparam int       FramesPerMinute = 75 * 60;
   localparam addr_type FrameLimit      = 19'd449999;
   localparam byte_type FillerByte      = 8'h04;
   localparam byte_type ZeroByte        = 8'h00;
   localparam int       FrameBytes      = 13;
   localparam int       SumBytes        = 11;
   localparam int       FillerPos       = 7;
   localparam int       ChecksumPos     = 11;
   localparam logic [3:0] FirstPos      = 4'd0;
   localparam logic [3:0] LastPos       = 4'd12;

   // reciprocal multipliers; each estimate is low by at most one
   localparam int MinRecip = 7456;   // ~ 2^25 / 4500
   localparam int MinShift = 25;
   localparam int SecRecip = 109;    // ~ 2^13 / 75
   localparam int SecShift = 13;

   // stages through the address conversion pipe
   localparam int MsfLatency = 8;

   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // two-digit BCD of a value below 100; tens by multiply-by-205 >> 11
   function automatic byte_type to_bcd(logic [6:0] n);
      logic [17:0] scaled;
      logic [3:0]  tens;
      logic [6:0]  ones;
      scaled = 18'(n) * 18'd205;
      tens   = scaled[14:11];
      ones   = n - 7'(7'(tens) * 7'd10);
      return {tens, ones[3:0]};
   endfunction

endpackage

// File: rtl/core/cdsf_channels.sv
// cdsf_channels: valid/ready channel interfaces for status requests and frame bytes.
// Standalone; the payload widths follow the frame builder's fields.
interface cdsf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  operation;
   logic [7:0]  subq_byte;
   logic [7:0]  track_bcd;
   logic [7:0]  index_value;
   logic [18:0] relative_frame_address;
   logic [18:0] absolute_frame_address;

   modport source (output valid, operation, subq_byte, track_bcd, index_value,
                   relative_frame_address, absolute_frame_address, input ready);
   modport sink   (input valid, operation, subq_byte, track_bcd, index_value,
                   relative_frame_address, absolute_frame_address, output ready);
endinterface

interface cdsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [3:0] byte_position;
   logic       last;

   modport source (output valid, byte_value, byte_position, last, input ready);
   modport sink   (input valid, byte_value, byte_position, last, output ready);
endinterface

// File: rtl/core/cdsf_msf.sv
// cdsf_msf: eight-stage pipe, frame address -> saturated M/S/F in BCD.
// Depends on cdsf_pkg.
module cdsf_msf import cdsf_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  addr_type        addr,
   output logic [2:0][7:0] msf_bcd
);

   addr_type    a1_ff, a1_in, a2_ff, a2_in;
   logic [31:0] min_prod;
   logic [19:0] min_back;
   logic [6:0]  m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in, m5_ff, m5_in;
   logic [6:0]  m6_ff, m6_in, m7_ff, m7_in;
   logic [13:0] r3_ff, r3_in;
   logic [12:0] r4_ff, r4_in, r5_ff, r5_in;
   logic [19:0] sec_prod;
   logic [12:0] sec_back;
   logic [5:0]  s5_ff, s5_in, s6_ff, s6_in, s7_ff, s7_in;
   logic [7:0]  f6_ff, f6_in;
   logic [6:0]  f7_ff, f7_in;
   logic [2:0][7:0] bcd_ff, bcd_in;

   always_comb begin
      // saturate
      a1_in = (addr > FrameLimit) ? FrameLimit : addr;
      // minutes estimate
      min_prod = 32'(a1_ff) * 32'(MinRecip);
      m2_in    = min_prod[MinShift +: 7];
      a2_in    = a1_ff;
      // remainder against the estimate, below two minutes
      min_back = 20'(m2_ff) * 20'(FramesPerMinute);
      r3_in    = 14'(a2_ff - min_back[18:0]);
      m3_in    = m2_ff;
      // fix a low estimate
      if (r3_ff >= 14'(FramesPerMinute)) begin
         r4_in = 13'(r3_ff - 14'(FramesPerMinute));
         m4_in = m3_ff + 7'd1;
      end else begin
         r4_in = r3_ff[12:0];
         m4_in = m3_ff;
      end
      // seconds estimate
      sec_prod = 20'(r4_ff) * 20'(SecRecip);
      s5_in    = sec_prod[SecShift +: 6];
      r5_in    = r4_ff;
      m5_in    = m4_ff;
      sec_back = 13'(s5_ff) * 13'(FramesPerSecond);
      f6_in    = 8'(r5_ff - sec_back);
      s6_in    = s5_ff;
      m6_in    = m5_ff;
      if (f6_ff >= 8'(FramesPerSecond)) begin
         f7_in = 7'(f6_ff - 8'(FramesPerSecond));
         s7_in = s6_ff + 6'd1;
      end else begin
         f7_in = f6_ff[6:0];
         s7_in = s6_ff;
      end
      m7_in = m6_ff;
      bcd_in[0] = to_bcd(m7_ff);
      bcd_in[1] = to_bcd({1'b0, s7_ff});
      bcd_in[2] = to_bcd(f7_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= a1_in;
         a2_ff  <= a2_in;
         m2_ff  <= m2_in;
         r3_ff  <= r3_in;
         m3_ff  <= m3_in;
         r4_ff  <= r4_in;
         m4_ff  <= m4_in;
         s5_ff  <= s5_in;
         r5_ff  <= r5_in;
         m5_ff  <= m5_in;
         f6_ff  <= f6_in;
         s6_ff  <= s6_in;
         m6_ff  <= m6_in;
         f7_ff  <= f7_in;
         s7_ff  <= s7_in;
         m7_ff  <= m7_in;
         bcd_ff <= bcd_in;
      end
   end

   assign msf_bcd = bcd_ff;

endmodule

// File: rtl/core/cdsf_front.sv
// cdsf_front: accepts status requests, converts both addresses, builds the checksummed frame.
// Depends on cdsf_pkg, cdsf_channels and cdsf_msf.
module cdsf_front import cdsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cdsf_req_if.sink      req_chan,
   output frame_msg_type out_msg,
   input  logic          out_ready
);

   logic                              en;
   logic [MsfLatency-1:0]             valid_ff, valid_in;
   logic [MsfLatency-1:0][3:0][7:0]   pass_ff, pass_in;
   logic [2:0][7:0]                   rel_bcd, abs_bcd;
   frame_type                         frame_in, frame_ff;
   logic                              out_valid_ff, out_valid_in;
   byte_type                          sum;

   // whole pipe moves together; only a full output slot holds it
   assign en             = !out_valid_ff || out_ready;
   assign req_chan.ready = en;

   cdsf_msf u_rel (
      .clock   (clock),
      .en      (en),
      .addr    (req_chan.relative_frame_address),
      .msf_bcd (rel_bcd)
   );

   cdsf_msf u_abs (
      .clock   (clock),
      .en      (en),
      .addr    (req_chan.absolute_frame_address),
      .msf_bcd (abs_bcd)
   );

   always_comb begin
      valid_in[0]   = req_chan.valid;
      pass_in[0][0] = req_chan.operation;
      pass_in[0][1] = req_chan.subq_byte;
      pass_in[0][2] = req_chan.track_bcd;
      pass_in[0][3] = req_chan.index_value;
      for (int i = 1; i < MsfLatency; i++) begin
         valid_in[i] = valid_ff[i-1];
         pass_in[i]  = pass_ff[i-1];
      end

      for (int i = 0; i < 4; i++) begin
         frame_in[i] = pass_ff[MsfLatency-1][i];
      end
      for (int i = 0; i < 3; i++) begin
         frame_in[4+i] = rel_bcd[i];
         frame_in[8+i] = abs_bcd[i];
      end
      frame_in[FillerPos] = FillerByte;
      sum = ZeroByte;
      for (int i = 0; i < SumBytes; i++) begin
         sum = sum + frame_in[i];
      end
      frame_in[ChecksumPos] = ~sum;
      out_valid_in = valid_ff[MsfLatency-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass_ff  <= pass_in;
         frame_ff <= frame_in;
      end
   end

   assign out_msg.valid = out_valid_ff;
   assign out_msg.frame = frame_ff;

endmodule

// File: rtl/core/cdsf_queue.sv
// cdsf_queue: two-entry frame queue between the front and back parts.
// Depends on cdsf_pkg.
module cdsf_queue import cdsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  frame_msg_type wr_msg,
   output logic          wr_ready,
   output frame_msg_type rd_msg,
   input  logic          rd_ready
);

   frame_type                 entry_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]   count_ff, count_in;
   logic                      push, pop;

   assign wr_ready     = count_ff != QueueCntBits'(QueueDepth);
   assign rd_msg.valid = count_ff != '0;
   assign rd_msg.frame = entry_ff[rd_ptr_ff];
   assign push         = wr_msg.valid && wr_ready;
   assign pop          = rd_msg.valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QueueCntBits'(push) - QueueCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_msg.frame;
      end
   end

endmodule

// File: rtl/core/cdsf_back.sv
// cdsf_back: shifts a queued frame out one byte per handshake, zero byte last.
// Depends on cdsf_pkg and cdsf_channels.
module cdsf_back import cdsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  frame_msg_type in_msg,
   output logic          in_ready,
   cdsf_rsp_if.source    rsp_chan
);

   logic [FrameBytes-1:0][7:0] shift_ff, shift_in;
   logic [3:0]                 pos_ff, pos_in;
   logic                       valid_ff, valid_in;
   logic                       fire, at_last, load;

   assign fire     = valid_ff && rsp_chan.ready;
   assign at_last  = pos_ff == LastPos;
   assign in_ready = !valid_ff || (fire && at_last);
   assign load     = in_msg.valid && in_ready;

   always_comb begin
      shift_in = shift_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         shift_in = {ZeroByte, in_msg.frame};
         pos_in   = FirstPos;
         valid_in = 1'b1;
      end else if (fire) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            shift_in = {ZeroByte, shift_ff[FrameBytes-1:1]};
            pos_in   = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= FirstPos;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.byte_value    = shift_ff[0];
   assign rsp_chan.byte_position = pos_ff;
   assign rsp_chan.last          = at_last;

endmodule

// File: rtl/core/cd_status_frame_builder.sv
// cd_status_frame_builder: top level of the CD drive status frame builder.
// Depends on cdsf_pkg, cdsf_channels, cdsf_front, cdsf_queue and cdsf_back.
//
//   channel   dir  moves                                      handshake
//   req_chan  in   one status request (op, subq, track, idx,   valid/ready
//                  relative and absolute frame address)
//   rsp_chan  out  one frame byte + position + last flag       valid/ready
//
// Cycles: a request enters every cycle while the front has room; its first
//   byte passes the nine front stages, the queue and the shifter's load.
//   The byte-wide result port sets the sustained rate, as each request gives 13 bytes.
// Reset: synchronous; clears pipe valids, queue pointers and the byte counter.
// Stalls: the two-entry queue parts the front from the byte shifter; the
//   front holds (req ready low) only while its output stage and the queue
//   are both full.
module cd_status_frame_builder import cdsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cdsf_req_if.sink   req_chan,
   cdsf_rsp_if.source rsp_chan
);

   frame_msg_type front_msg;   // front -> queue
   frame_msg_type queue_msg;   // queue -> back
   logic          front_ready;
   logic          back_ready;

   cdsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_msg   (front_msg),
      .out_ready (front_ready)
   );

   cdsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_msg   (front_msg),
      .wr_ready (front_ready),
      .rd_msg   (queue_msg),
      .rd_ready (back_ready)
   );

   cdsf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_msg   (queue_msg),
      .in_ready (back_ready),
      .rsp_chan (rsp_chan)
   );

   // front only backs up when a finished frame finds the queue full
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (front_msg.valid && !front_ready))
      else $error("request port stalled without a full queue");

   // bytes of one frame come out in order
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=>
      (rsp_chan.valid && (rsp_chan.byte_position == $past(rsp_chan.byte_position) + 4'd1)))
      else $error("frame byte position skipped");

   // a new frame starts right after the last byte if one is queued, else the port idles
   a_frame_turn: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=>
      ((rsp_chan.valid && (rsp_chan.byte_position == FirstPos)) == $past(queue_msg.valid)))
      else $error("frame hand-over between queue and shifter broken");

   // trailing byte is always zero
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last) |-> (rsp_chan.byte_value == ZeroByte))
      else $error("final frame byte not zero");

endmodule
